@@ rtl/bssht_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bssht_pkg
// shared types and constants of the bucketed split-sequence hash table
// ---------------------------------------------------------------------------
package bssht_pkg;

    localparam int NUM_BUCKETS_DEF  = 256;
    localparam int BUCKET_SLOTS_DEF = 4;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // slot marks
    localparam logic [1:0] MK_EMPTY = 2'd0;
    localparam logic [1:0] MK_DEAD  = 2'd1;
    localparam logic [1:0] MK_LIVE  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_POWER = 2'd1;
    localparam logic [1:0] REG_SLOW  = 2'd2;
    localparam logic [1:0] REG_SHIGH = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] key;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [10:0] key_count;
    } t_out_word;

endpackage
`default_nettype wire

@@ rtl/bucketed_split_sequence_hash_table_core.sv @@
`default_nettype none
// a word whose home bucket decides passes the home remainder, row read and evaluation states;
// each further probe adds a multiply and a 64-step serial modulo, the high-step pass restarts
// at the home bucket, and a found value adds the S_VRD and S_VWAIT states for its read
// throughput: one operation at a time; the next word is taken once the result word leaves
// clear: a sweep that zeroes the mark row of every bucket; reset: the same mark sweep, no word taken then
// ---------------------------------------------------------------------------
// bucketed_split_sequence_hash_table_core
// key/value hash table held in row memories of one bucket per row
// ---------------------------------------------------------------------------
module bucketed_split_sequence_hash_table_core #(
    parameter int NUM_BUCKETS  = bssht_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_SLOTS = bssht_pkg::BUCKET_SLOTS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire bssht_pkg::t_in_word i_data,
    output logic                   o_valid,
    input  wire                    i_stall,
    output bssht_pkg::t_out_word   o_data,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [1:0]              i_cfg_index,
    input  wire [31:0]             i_cfg_data
);
    import bssht_pkg::*;

    localparam int AW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int NW  = $clog2(NUM_BUCKETS + 1);

    // states
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HOME  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_CLEAR = 4'd9;
    localparam logic [3:0] S_VRD   = 4'd10;
    localparam logic [3:0] S_VWAIT = 4'd11;

    // configuration
    logic [8:0]  r_size;
    logic [4:0]  r_power;
    logic [30:0] r_slow, r_shigh;

    // bucket rows
    logic [2*BUCKET_SLOTS-1:0]  mem_mark [NUM_BUCKETS];
    logic [31*BUCKET_SLOTS-1:0] mem_key  [NUM_BUCKETS];
    logic [32*BUCKET_SLOTS-1:0] mem_val  [NUM_BUCKETS];
    logic [2*BUCKET_SLOTS-1:0]  r_rd_mark;
    logic [31*BUCKET_SLOTS-1:0] r_rd_key;
    logic [31:0]                r_rd_val;
    logic                       r_mk_we, r_kv_we;
    logic [AW-1:0]              r_mk_wa;
    logic [2*BUCKET_SLOTS-1:0]  r_mk_wd;
    logic [SW-1:0]              r_kv_slot;
    logic [SW-1:0]              r_vslot;

    logic [3:0]  r_state;
    logic [1:0]  r_op;
    logic [30:0] r_key;
    logic [31:0] r_val;
    logic [NW-1:0] r_n;
    logic [AW-1:0] r_adr;
    logic [NW-1:0] r_att;
    logic          r_pass;
    logic [30:0]   r_step;
    logic [63:0]   r_rem;
    logic [6:0]    r_bit;
    logic [10:0]   r_count;
    logic [AW-1:0] r_clr;
    logic          r_ovalid;
    t_out_word     r_out;

    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 9'd256;
            r_power <= 5'd8;
            r_slow  <= 31'd1000000007;
            r_shigh <= 31'd1000000007;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIZE:  r_size  <= i_cfg_data[8:0];
                REG_POWER: r_power <= i_cfg_data[4:0];
                REG_SLOW:  r_slow  <= i_cfg_data[30:0];
                REG_SHIGH: r_shigh <= i_cfg_data[30:0];
                default:   r_size  <= r_size;
            endcase
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_mk_we) mem_mark[r_mk_wa] <= r_mk_wd;
        if (r_kv_we) begin
            mem_key[r_adr][31*r_kv_slot +: 31] <= r_key;
            mem_val[r_adr][32*r_kv_slot +: 32] <= r_val;
        end
        r_rd_mark <= mem_mark[r_adr];
        r_rd_key  <= mem_key[r_adr];
        r_rd_val  <= mem_val[r_adr][32*r_vslot +: 32];
    end

    // bucket evaluation
    logic              hit, free_found, unused;
    logic [SW-1:0]     hit_slot, free_slot;
    logic [30:0]       first_key;
    always_comb begin
        hit = 1'b0; free_found = 1'b0; unused = 1'b1;
        hit_slot = '0; free_slot = '0;
        first_key = r_rd_key[30:0];
        for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
            if (r_rd_mark[2*i +: 2] == MK_LIVE && r_rd_key[31*i +: 31] == r_key) begin
                hit = 1'b1; hit_slot = SW'(i);
            end
            if (r_rd_mark[2*i +: 2] != MK_LIVE) begin
                free_found = 1'b1; free_slot = SW'(i);
            end
            if (r_rd_mark[2*i +: 2] != MK_EMPTY) unused = 1'b0;
        end
    end

    // marks row after an insert or a delete
    logic [2*BUCKET_SLOTS-1:0] mark_upd;
    always_comb begin
        mark_upd = r_rd_mark;
        if (r_op == OP_INSERT) mark_upd[2*free_slot +: 2] = MK_LIVE;
        else mark_upd[2*hit_slot +: 2] = MK_DEAD;
    end

    // memory write strobes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mk_we <= 1'b0;
            r_kv_we <= 1'b0;
        end else begin
            r_mk_we <= (r_state == S_INIT) || (r_state == S_CLEAR) ||
                       ((r_state == S_EVAL) &&
                        ((r_op == OP_INSERT && !hit && free_found) ||
                         (r_op == OP_DELETE && hit)));
            r_kv_we <= (r_state == S_EVAL) && (r_op == OP_INSERT) && !hit && free_found;
        end
    end

    logic [NW-1:0] n_clamp;
    always_comb begin
        if (r_size == 9'd0) n_clamp = NW'(1);
        else if (32'(r_size) > 32'(NUM_BUCKETS)) n_clamp = NW'(NUM_BUCKETS);
        else n_clamp = NW'(r_size);
    end

    logic [30:0] masked_key;
    assign masked_key = (r_power == 5'd31) ? r_key :
                        (r_key & ((31'd1 << r_power) - 31'd1));

    // restoring remainder step over r_rem against n
    logic [NW-1:0] r_acc;
    logic [NW:0]   acc_sh, acc_try;
    assign acc_sh  = {r_acc, r_rem[63]};
    assign acc_try = acc_sh - {1'b0, r_n};

    logic [NW-1:0] n_att;
    assign n_att = r_att + NW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_vslot  <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_INIT, S_CLEAR: begin
                    r_mk_wa <= r_clr; r_mk_wd <= '0;
                    if (32'(r_clr) == 32'(NUM_BUCKETS - 1)) begin
                        r_clr <= '0;
                        if (r_state == S_CLEAR) begin
                            r_out <= '{status: ST_OK, value_out: '0, key_count: '0};
                            r_count  <= '0;
                            r_state  <= S_DONE;
                        end else r_state <= S_IDLE;
                    end else r_clr <= r_clr + AW'(1);
                end
                S_IDLE: if (i_valid && !o_stall) begin
                    r_op  <= i_data.opcode; r_key <= i_data.key; r_val <= i_data.value;
                    r_n   <= n_clamp; r_pass <= 1'b0; r_att <= '0;
                    r_step <= r_slow;
                    if (i_data.opcode == OP_CLEAR) r_state <= S_CLEAR;
                    else r_state <= S_HOME;
                end
                S_HOME: begin
                    // home bucket via serial remainder of masked key
                    r_rem <= {masked_key, 33'd0}; r_acc <= '0; r_bit <= 7'd31;
                    r_state <= S_MOD;
                end
                S_MUL: begin
                    r_rem <= 64'(r_adr) + 64'(r_step) * 64'(r_att);
                    r_acc <= '0; r_bit <= 7'd64;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_rem <= {r_rem[62:0], 1'b0};
                    r_acc <= acc_try[NW] ? acc_sh[NW-1:0] : acc_try[NW-1:0];
                    r_bit <= r_bit - 7'd1;
                    if (r_bit == 7'd1) r_state <= S_RD;
                end
                S_RD: begin
                    r_adr <= AW'(r_acc);
                    r_state <= S_WAIT;
                end
                S_WAIT: r_state <= S_EVAL;
                S_EVAL: begin
                    if (r_op == OP_INSERT) begin
                        if (hit) begin
                            r_out <= '{status: ST_DUP, value_out: '0, key_count: r_count};
                            r_state <= S_DONE;
                        end else if (free_found) begin
                            r_mk_wa <= r_adr;
                            r_mk_wd <= mark_upd;
                            r_kv_slot <= free_slot;
                            r_count <= r_count + 11'd1;
                            r_out <= '{status: ST_OK, value_out: '0,
                                       key_count: r_count + 11'd1};
                            r_state <= S_DONE;
                        end else begin
                            r_att <= n_att;
                            if (r_att == '0)
                                r_step <= (first_key < r_key) ? r_slow : r_shigh;
                            if (n_att >= r_n) begin
                                r_out <= '{status: ST_FULL, value_out: '0,
                                           key_count: r_count};
                                r_state <= S_DONE;
                            end else r_state <= S_MUL;
                        end
                    end else if (hit) begin
                        if (r_op == OP_DELETE) begin
                            r_mk_wa <= r_adr;
                            r_mk_wd <= mark_upd;
                            r_count <= r_count - 11'd1;
                            r_out <= '{status: ST_OK, value_out: '0,
                                       key_count: r_count - 11'd1};
                            r_state <= S_DONE;
                        end else begin
                            r_vslot <= hit_slot;
                            r_state <= S_VRD;
                        end
                    end else if (unused || n_att >= r_n) begin
                        if (r_pass) begin
                            r_out <= '{status: ST_NONE, value_out: '0, key_count: r_count};
                            r_state <= S_DONE;
                        end else begin
                            r_pass <= 1'b1; r_att <= '0; r_step <= r_shigh;
                            r_state <= S_HOME;
                        end
                    end else begin
                        r_att <= n_att;
                        r_state <= S_MUL;
                    end
                end
                S_VRD: r_state <= S_VWAIT;
                S_VWAIT: begin
                    r_out <= '{status: ST_OK, value_out: r_rd_val, key_count: r_count};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_ovalid) else $error("result lost");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_IDLE) |-> !r_kv_we)
        else $error("stray write");
endmodule
`default_nettype wire

@@ sim/bucketed_split_sequence_hash_table_core_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bucketed_split_sequence_hash_table_core_tb
// self-checking bench for the bucketed split-sequence hash table: words are
// sent with random gaps, a software table inside the bench predicts every
// result word, and the returned words are compared field by field in order
// ---------------------------------------------------------------------------
module bucketed_split_sequence_hash_table_core_tb;
    import bssht_pkg::*;

    localparam int TOTAL_SLOTS = NUM_BUCKETS_DEF * BUCKET_SLOTS_DEF;
    localparam int SETTLE      = 400;
    localparam int STALL_LIMIT = 200000;
    localparam int POOL        = 24;
    localparam int RING        = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_word    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_word   o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    bucketed_split_sequence_hash_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow table
    logic [30:0] tbl_key  [TOTAL_SLOTS];
    logic [31:0] tbl_val  [TOTAL_SLOTS];
    logic [1:0]  tbl_mark [TOTAL_SLOTS];
    int unsigned tbl_live;
    logic [8:0]  cfg_size;
    logic [4:0]  cfg_power;
    logic [30:0] cfg_step_lo;
    logic [30:0] cfg_step_hi;

    // expected result words, oldest at exp_head
    t_out_word   exp_ring[RING];
    int          exp_head;
    int          exp_tail;
    logic [30:0] key_pool[POOL];
    int          fails;
    int          words_sent;
    int          words_checked;
    int          cfg_writes;
    int          idle_cycles;
    bit          calm;
    int          holds_asked;
    int          holds_done;
    int          hold_left;

    always #5 i_clk = ~i_clk;

    // ---- prediction ----
    function automatic int unsigned buckets_used();
        if (cfg_size < 1) return 1;
        if (cfg_size > NUM_BUCKETS_DEF) return NUM_BUCKETS_DEF;
        return 32'(cfg_size);
    endfunction

    function automatic int unsigned home_of(logic [30:0] key, int unsigned n);
        logic [31:0] k;
        k = {1'b0, key};
        if (cfg_power < 31) k &= (32'd1 << cfg_power) - 32'd1;
        return k % n;
    endfunction

    function automatic int unsigned probe_next(int unsigned adr, logic [30:0] step,
                                               int unsigned att, int unsigned n);
        longint unsigned t;
        t = longint'(adr) + longint'(step) * longint'(att);
        return 32'(t % n);
    endfunction

    function automatic int slot_of(int unsigned b, logic [30:0] key);
        for (int i = 0; i < BUCKET_SLOTS_DEF; i++)
            if (tbl_mark[b*BUCKET_SLOTS_DEF+i] == MK_LIVE && tbl_key[b*BUCKET_SLOTS_DEF+i] == key)
                return b*BUCKET_SLOTS_DEF+i;
        return -1;
    endfunction

    function automatic bit bucket_fresh(int unsigned b);
        for (int i = 0; i < BUCKET_SLOTS_DEF; i++)
            if (tbl_mark[b*BUCKET_SLOTS_DEF+i] != MK_EMPTY) return 0;
        return 1;
    endfunction

    // low-step sequence first, then high-step sequence
    function automatic int lookup_slot(logic [30:0] key);
        int unsigned n, att, adr;
        logic [30:0] step;
        int s;
        n = buckets_used();
        for (int pass = 0; pass < 2; pass++) begin
            step = (pass == 0) ? cfg_step_lo : cfg_step_hi;
            att = 0;
            adr = 0;
            do begin
                adr = (att == 0) ? home_of(key, n) : probe_next(adr, step, att, n);
                s = slot_of(adr, key);
                if (s >= 0) return s;
                att++;
            end while (!bucket_fresh(adr) && att < n);
        end
        return -1;
    endfunction

    function automatic logic [1:0] place_key(logic [30:0] key, logic [31:0] value);
        int unsigned n, att, adr, s;
        logic [30:0] step, first;
        bit have;
        n = buckets_used();
        att = 0;
        adr = 0;
        step = cfg_step_lo;
        do begin
            have = 0;
            first = '0;
            adr = (att == 0) ? home_of(key, n) : probe_next(adr, step, att, n);
            if (slot_of(adr, key) >= 0) return ST_DUP;
            for (int i = 0; i < BUCKET_SLOTS_DEF; i++) begin
                s = adr*BUCKET_SLOTS_DEF + i;
                if (tbl_mark[s] != MK_LIVE) begin
                    tbl_mark[s] = MK_LIVE;
                    tbl_key[s]  = key;
                    tbl_val[s]  = value;
                    tbl_live++;
                    return ST_OK;
                end
                if (!have) begin
                    first = tbl_key[s];
                    have = 1;
                end
            end
            if (att == 0) step = (have && first < key) ? cfg_step_lo : cfg_step_hi;
            att++;
        end while (att < n);
        return ST_FULL;
    endfunction

    function automatic t_out_word table_op(t_in_word w);
        t_out_word r;
        int s;
        r = '0;
        case (w.opcode)
            OP_INSERT: r.status = place_key(w.key, w.value);
            OP_DELETE: begin
                s = lookup_slot(w.key);
                if (s >= 0) begin
                    tbl_mark[s] = MK_DEAD;
                    tbl_live--;
                end else r.status = ST_NONE;
            end
            OP_FIND: begin
                s = lookup_slot(w.key);
                if (s >= 0) r.value_out = tbl_val[s];
                else r.status = ST_NONE;
            end
            default: begin
                for (int i = 0; i < TOTAL_SLOTS; i++) tbl_mark[i] = MK_EMPTY;
                tbl_live = 0;
            end
        endcase
        r.key_count = tbl_live[10:0];
        return r;
    endfunction

    // ---- result side: random stall, long hold-off on request, checking ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            i_stall <= 1'b1;
            hold_left <= 600;
            holds_done <= holds_done + 1;
        end else begin
            i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 9);
        end

        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_head == exp_tail) begin
                $error("result word with nothing expected: %p", o_data);
                fails++;
            end else begin
                t_out_word e;
                e = exp_ring[exp_head % RING];
                exp_head++;
                if (o_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_data.status);
                    fails++;
                end
                if (o_data.value_out !== e.value_out) begin
                    $error("value_out expected %h actual %h", e.value_out, o_data.value_out);
                    fails++;
                end
                if (o_data.key_count !== e.key_count) begin
                    $error("key_count expected %0d actual %0d", e.key_count, o_data.key_count);
                    fails++;
                end
                words_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without progress", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---- sending side ----
    task automatic send_word(logic [1:0] op, logic [30:0] key, logic [31:0] value);
        t_in_word w;
        w.opcode = op;
        w.key    = key;
        w.value  = value;
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        exp_ring[exp_tail % RING] = table_op(w);
        exp_tail++;
        words_sent++;
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (exp_head != exp_tail) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SIZE:  cfg_size    = data[8:0];
            REG_POWER: cfg_power   = data[4:0];
            REG_SLOW:  cfg_step_lo = data[30:0];
            default:   cfg_step_hi = data[30:0];
        endcase
        cfg_writes++;
    endtask

    task automatic set_table(logic [31:0] size, logic [31:0] power,
                             logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_SIZE, size);
        write_reg(REG_POWER, power);
        write_reg(REG_SLOW, lo);
        write_reg(REG_SHIGH, hi);
    endtask

    // ---- tests ----
    // basic operations at reset settings, extremes of every field
    task automatic test_basic_ops();
        send_word(OP_FIND,   31'd0, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 31'd0, 32'h0000_0000);
        send_word(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 31'h7FFF_FFFF, 32'h1234_5678);
        send_word(OP_FIND,   31'h7FFF_FFFF, 32'h0);
        send_word(OP_FIND,   31'd0, 32'h0);
        send_word(OP_DELETE, 31'd0, 32'hA5A5_A5A5);
        send_word(OP_DELETE, 31'd0, 32'h0);
        send_word(OP_FIND,   31'd0, 32'h0);
        send_word(OP_CLEAR,  31'h5555_5555, 32'h5A5A_5A5A);
        send_word(OP_FIND,   31'h7FFF_FFFF, 32'h0);
    endtask

    // size below range clamps to one bucket with zero steps; the fifth insert finds it full
    task automatic test_single_bucket();
        set_table(32'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 5; i++) send_word(OP_INSERT, 31'(i * 7 + 1), 32'(i + 100));
        send_word(OP_FIND, 31'd15, 32'h0);
        send_word(OP_FIND, 31'd29, 32'h0);
    endtask

    // size above range clamps, whole key hashed, then resize with keys held
    task automatic test_wide_keys_and_resize();
        set_table(32'hFFFF_FFFF, 32'd31, 32'h7FFF_FFFF, 32'd1);
        send_word(OP_INSERT, 31'h4000_0123, 32'hDEAD_BEEF);
        send_word(OP_INSERT, 31'h0000_0123, 32'hCAFE_F00D);
        write_reg(REG_SIZE, 32'd3);
        send_word(OP_FIND, 31'h4000_0123, 32'h0);
        send_word(OP_FIND, 31'h0000_0123, 32'h0);
        send_word(OP_CLEAR, 31'h0, 32'h0);
    endtask

    function automatic logic [30:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, POOL-1)];
            6:       return 31'($urandom_range(0, 600));
            default: return 31'($urandom);
        endcase
    endfunction

    // random mix on a given table shape, keys mostly from a reused pool
    task automatic test_random_phase(int count, logic [31:0] size, logic [31:0] power,
                                     logic [31:0] lo, logic [31:0] hi, bit squeeze);
        int r;
        set_table(size, power, lo, hi);
        for (int i = 0; i < POOL; i++)
            key_pool[i] = (i % 3 == 0) ? 31'($urandom) : 31'($urandom_range(0, 2000));
        for (int i = 0; i < count; i++) begin
            if (squeeze && i == count / 3) holds_asked++;
            r = $urandom_range(0, 99);
            if (r < 45)      send_word(OP_INSERT, pick_key(), $urandom);
            else if (r < 70) send_word(OP_FIND, pick_key(), $urandom);
            else if (r < 97) send_word(OP_DELETE, pick_key(), $urandom);
            else             send_word(OP_CLEAR, pick_key(), $urandom);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SIZE;
        i_cfg_data = '0;
        fails = 0;
        words_sent = 0;
        words_checked = 0;
        cfg_writes = 0;
        idle_cycles = 0;
        calm = 1'b0;
        holds_asked = 0;
        holds_done = 0;
        exp_head = 0;
        exp_tail = 0;
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_val[i] = '0;
            tbl_mark[i] = MK_EMPTY;
        end
        tbl_live = 0;
        cfg_size = 9'd256;
        cfg_power = 5'd8;
        cfg_step_lo = 31'd1000000007;
        cfg_step_hi = 31'd1000000007;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_single_bucket();
        test_wide_keys_and_resize();

        test_random_phase(247, 32'd4, 32'd3, 32'd1, 32'd3, 1'b0);
        test_random_phase(247, 32'd16, 32'd31, 32'h7FFF_FFFF, 32'd0, 1'b1);
        calm = 1'b1;
        test_random_phase(247, 32'd7, 32'd5, $urandom, $urandom, 1'b0);
        calm = 1'b0;
        test_random_phase(247, 32'd1, 32'd0, 32'd1, 32'd1, 1'b0);
        test_random_phase(247, 32'd256, 32'd8, 32'd1000000007, 32'd1000000007, 1'b0);
        test_random_phase(247, 32'($urandom_range(2, 40)), 32'($urandom_range(0, 31)),
                          $urandom, $urandom, 1'b0);
        test_random_phase(247, 32'd511, 32'd2, 32'd5, 32'd2, 1'b0);

        drain();
        $display("covered %0d words, %0d results checked, %0d register writes",
                 words_sent, words_checked, cfg_writes);
        $display("table shapes from one bucket to full size, clamped sizes, zero steps");
        if (fails == 0 && exp_head == exp_tail)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
